// File: hdl/pucl_pkg.sv
// ----------------------------------------------------------------------------
// pucl_pkg
// Types and constants shared by the per-user connection limiter.
// ----------------------------------------------------------------------------
package pucl_pkg;

  localparam int CNT_W  = 11;
  localparam int USER_W = 32;
  localparam int CONN_W = 22;
  localparam int ST_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int unsigned ABS_MAX_CONN = 1000;
  localparam logic [CNT_W-1:0] RST_LIMIT = 11'd40;

  localparam logic KIND_OPEN  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  localparam logic TBL_USER = 1'b0;
  localparam logic TBL_CONN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKUP     = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_ACCEPTED     = 3'd0,
    ST_DENIED       = 3'd1,
    ST_BUSY         = 3'd2,
    ST_CLOSED       = 3'd3,
    ST_UNKNOWN      = 3'd4,
    ST_INCONSISTENT = 3'd5
  } status_e;

  typedef struct packed {
    logic              kind;
    logic [USER_W-1:0] user_id;
    logic [CONN_W-1:0] conn_id;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] user_count;
    logic [CNT_W-1:0] open_count;
  } out_item_t;

  typedef struct packed {
    logic [USER_W-1:0] key;
    logic [CNT_W-1:0]  cnt;
  } user_ent_t;

  typedef struct packed {
    logic [CONN_W-1:0] key;
    logic [USER_W-1:0] owner;
  } conn_ent_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    scan_clr;
    logic    scan_run;
    logic    scan_tbl;
    logic    open_commit;
    logic    rd_last_user;
    logic    user_close_wr;
    logic    rd_last_conn;
    logic    conn_remove;
    logic    res_load;
    status_e res_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_hit;
    logic scan_miss;
    logic at_glimit;
    logic at_ulimit;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: hdl/pucl_dp.sv
// ----------------------------------------------------------------------------
// pucl_dp
// Datapath: config registers, connection and user tables, linear search
// unit, counters and the result register.
// ----------------------------------------------------------------------------
module pucl_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pucl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pucl_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  pucl_pkg::in_item_t                   in_data_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output pucl_pkg::out_item_t                  out_data_o,
  input  pucl_pkg::dp_cmd_t                    cmd_i,
  output pucl_pkg::dp_stat_t                   stat_o
);

  localparam int CW = pucl_pkg::CNT_W;
  // the global limit never exceeds the absolute cap, so the tables need at most 1024 entries
  localparam int MEM_DEPTH = (TABLE_DEPTH < 1024) ? TABLE_DEPTH : 1024;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned CAP_INT =
    (TABLE_DEPTH < pucl_pkg::ABS_MAX_CONN) ? TABLE_DEPTH : pucl_pkg::ABS_MAX_CONN;
  localparam logic [CW-1:0] CAP = CW'(CAP_INT);

  // config
  logic [CW-1:0] max_conn_q, user_limit_q;
  logic          lookup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_conn_q   <= pucl_pkg::RST_LIMIT;
      user_limit_q <= pucl_pkg::RST_LIMIT;
      lookup_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pucl_pkg::CFG_MAX_CONN:   max_conn_q   <= cfg_data_i;
        pucl_pkg::CFG_USER_LIMIT: user_limit_q <= cfg_data_i;
        pucl_pkg::CFG_LOOKUP:     lookup_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] glim, glim_raw, ulim;
  always_comb begin
    glim_raw = (max_conn_q == '0) ? CW'(1) : max_conn_q;
    glim     = (glim_raw > CAP) ? CAP : glim_raw;
    ulim     = (!lookup_q || user_limit_q > glim) ? glim : user_limit_q;
  end

  // item registers
  logic [pucl_pkg::USER_W-1:0] user_q;
  logic [pucl_pkg::CONN_W-1:0] conn_q;

  // counters
  logic [CW-1:0] total_q, total_d, entries_q, entries_d;

  // tables
  pucl_pkg::user_ent_t user_mem [MEM_DEPTH];
  pucl_pkg::conn_ent_t conn_mem [MEM_DEPTH];
  pucl_pkg::user_ent_t user_rdata_q, user_wdata;
  pucl_pkg::conn_ent_t conn_rdata_q, conn_wdata;
  logic [AW-1:0] user_raddr, conn_raddr, user_waddr, conn_waddr;
  logic          user_we, conn_we;

  // search unit
  logic [CW-1:0] scan_cnt_q, scan_cnt_d, scan_len;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_idx_q;
  logic          match, issue, hit, miss;

  // captured search results
  logic [AW-1:0] user_idx_q, conn_idx_q;
  logic [CW-1:0] num_q, dec_cnt;
  logic [CW-1:0] last_user, last_conn;

  assign last_user = entries_q - CW'(1);
  assign last_conn = total_q - CW'(1);
  assign dec_cnt   = (num_q != '0) ? num_q - CW'(1) : '0;

  always_comb begin
    scan_len = (cmd_i.scan_tbl == pucl_pkg::TBL_USER) ? entries_q : total_q;
    match    = (cmd_i.scan_tbl == pucl_pkg::TBL_USER) ? (user_rdata_q.key == user_q)
                                                      : (conn_rdata_q.key == conn_q);
    hit      = cmd_i.scan_run && pend_q && match;
    miss     = cmd_i.scan_run && !pend_q && (scan_cnt_q >= scan_len);
    issue    = cmd_i.scan_run && !hit && (scan_cnt_q < scan_len);
    scan_cnt_d = scan_cnt_q;
    pend_d     = pend_q;
    if (cmd_i.scan_clr) begin
      scan_cnt_d = '0;
      pend_d     = 1'b0;
    end else if (cmd_i.scan_run) begin
      pend_d = issue;
      if (issue) begin
        scan_cnt_d = scan_cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      scan_cnt_q <= scan_cnt_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_idx_q <= scan_cnt_q[AW-1:0];
    end
  end

  // payload captures
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      user_q <= lookup_q ? in_data_i.user_id : '0;
      conn_q <= in_data_i.conn_id;
    end else if (hit && cmd_i.scan_tbl == pucl_pkg::TBL_CONN) begin
      // on close the owner becomes the user to look up
      user_q     <= conn_rdata_q.owner;
      conn_idx_q <= pend_idx_q;
    end
    if (hit && cmd_i.scan_tbl == pucl_pkg::TBL_USER) begin
      user_idx_q <= pend_idx_q;
      num_q      <= user_rdata_q.cnt;
    end else if (miss && cmd_i.scan_tbl == pucl_pkg::TBL_USER) begin
      num_q <= '0;
    end
  end

  // user entry found on the last user search (count of a missing user is zero
  // only if no entry was found, since stored counts are never zero)
  function automatic logic hit_user_valid();
    return num_q != '0;
  endfunction

  // table read and write addressing
  always_comb begin
    user_raddr = cmd_i.rd_last_user ? last_user[AW-1:0] : scan_cnt_q[AW-1:0];
    conn_raddr = cmd_i.rd_last_conn ? last_conn[AW-1:0] : scan_cnt_q[AW-1:0];

    user_we    = 1'b0;
    user_waddr = user_idx_q;
    user_wdata = '{key: user_q, cnt: num_q + CW'(1)};
    conn_we    = 1'b0;
    conn_waddr = total_q[AW-1:0];
    conn_wdata = '{key: conn_q, owner: user_q};
    entries_d  = entries_q;
    total_d    = total_q;

    if (cmd_i.open_commit) begin
      user_we = 1'b1;
      conn_we = 1'b1;
      total_d = total_q + CW'(1);
      if (hit_user_valid()) begin
        user_waddr = user_idx_q;
      end else begin
        user_waddr = entries_q[AW-1:0];
        user_wdata = '{key: user_q, cnt: CW'(1)};
        entries_d  = entries_q + CW'(1);
      end
    end
    if (cmd_i.user_close_wr) begin
      user_we    = 1'b1;
      user_waddr = user_idx_q;
      if (dec_cnt == '0) begin
        // swap the last user entry into the freed slot
        user_wdata = user_rdata_q;
        entries_d  = last_user;
      end else begin
        user_wdata = '{key: user_q, cnt: dec_cnt};
      end
    end
    if (cmd_i.conn_remove) begin
      conn_we    = 1'b1;
      conn_waddr = conn_idx_q;
      conn_wdata = conn_rdata_q;
      total_d    = last_conn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (user_we) begin
      user_mem[user_waddr] <= user_wdata;
    end
    user_rdata_q <= user_mem[user_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (conn_we) begin
      conn_mem[conn_waddr] <= conn_wdata;
    end
    conn_rdata_q <= conn_mem[conn_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      entries_q <= '0;
    end else begin
      total_q   <= total_d;
      entries_q <= entries_d;
    end
  end

  // result register
  logic                out_valid_q;
  pucl_pkg::out_item_t out_q;
  logic [CW-1:0]       res_ucount;

  always_comb begin
    case (cmd_i.res_status)
      pucl_pkg::ST_ACCEPTED: res_ucount = num_q + CW'(1);
      pucl_pkg::ST_DENIED:   res_ucount = num_q;
      pucl_pkg::ST_BUSY:     res_ucount = num_q;
      pucl_pkg::ST_CLOSED:   res_ucount = dec_cnt;
      default:               res_ucount = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q.status     <= cmd_i.res_status;
      out_q.user_count <= res_ucount;
      out_q.open_count <= total_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    stat_o.scan_hit  = hit;
    stat_o.scan_miss = miss;
    stat_o.at_glimit = total_q >= glim;
    stat_o.at_ulimit = num_q >= ulim;
    stat_o.out_busy  = out_valid_q && !out_ready_i;
  end

endmodule

// File: hdl/pucl_ctrl.sv
// ----------------------------------------------------------------------------
// pucl_ctrl
// Sequencer for open and close items: drives the searches, table updates
// and the result load.
// ----------------------------------------------------------------------------
module pucl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  output logic               in_ready_o,
  input  pucl_pkg::dp_stat_t stat_i,
  output pucl_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN_U = 9'b000000010,
    S_OP_DEC = 9'b000000100,
    S_SCAN_C = 9'b000001000,
    S_CL_URD = 9'b000010000,
    S_CL_UWR = 9'b000100000,
    S_CL_CRD = 9'b001000000,
    S_CL_CWR = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  pucl_pkg::status_e st_q, st_d;
  logic              kind_q, kind_d;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.res_status = st_q;
    in_ready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch    = 1'b1;
          cmd_o.scan_clr = 1'b1;
          kind_d         = in_kind_i;
          state_d = (in_kind_i == pucl_pkg::KIND_OPEN) ? S_SCAN_U : S_SCAN_C;
        end
      end
      S_SCAN_U: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.scan_tbl = pucl_pkg::TBL_USER;
        if (stat_i.scan_hit || stat_i.scan_miss) begin
          if (kind_q == pucl_pkg::KIND_OPEN) begin
            state_d = S_OP_DEC;
          end else if (stat_i.scan_hit) begin
            state_d = S_CL_URD;
          end else begin
            // owner has no user entry: still drop the connection
            st_d    = pucl_pkg::ST_INCONSISTENT;
            state_d = S_CL_CRD;
          end
        end
      end
      S_OP_DEC: begin
        if (stat_i.at_glimit) begin
          st_d = pucl_pkg::ST_BUSY;
        end else if (stat_i.at_ulimit) begin
          st_d = pucl_pkg::ST_DENIED;
        end else begin
          st_d = pucl_pkg::ST_ACCEPTED;
          cmd_o.open_commit = 1'b1;
        end
        state_d = S_DONE;
      end
      S_SCAN_C: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.scan_tbl = pucl_pkg::TBL_CONN;
        if (stat_i.scan_hit) begin
          cmd_o.scan_clr = 1'b1;
          state_d = S_SCAN_U;
        end else if (stat_i.scan_miss) begin
          st_d    = pucl_pkg::ST_UNKNOWN;
          state_d = S_DONE;
        end
      end
      S_CL_URD: begin
        cmd_o.rd_last_user = 1'b1;
        state_d = S_CL_UWR;
      end
      S_CL_UWR: begin
        cmd_o.user_close_wr = 1'b1;
        st_d    = pucl_pkg::ST_CLOSED;
        state_d = S_CL_CRD;
      end
      S_CL_CRD: begin
        cmd_o.rd_last_conn = 1'b1;
        state_d = S_CL_CWR;
      end
      S_CL_CWR: begin
        cmd_o.conn_remove = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= pucl_pkg::ST_ACCEPTED;
      kind_q  <= pucl_pkg::KIND_OPEN;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// File: hdl/per_user_connection_limiter.sv
// ----------------------------------------------------------------------------
// per_user_connection_limiter
// Admission table that limits open connections globally and per user.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------
//   input    | in        | in_valid_i / in_ready_o | in_data_i (in_item_t)
//   result   | out       | out_valid_o/out_ready_i | out_data_o(out_item_t)
//   config   | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One item at a time; each table has one read port, searched one entry per
// cycle. An open searches the user table, checks the limits and loads the
// result; a close searches the connection table and, on a hit, the user
// table, and removes what it finds before loading the result. Reset clears
// the counters, config and control only; tables need no clearing pass. A
// waiting result stalls the sequencer at its last step, before the next item is taken.
// ----------------------------------------------------------------------------
module per_user_connection_limiter #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pucl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pucl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pucl_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pucl_pkg::out_item_t             out_data_o
);

  pucl_pkg::dp_cmd_t  cmd;
  pucl_pkg::dp_stat_t stat;

  pucl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pucl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// File: tb/sv/per_user_connection_limiter_tb.sv
// ----------------------------------------------------------------------------
// per_user_connection_limiter_tb
// Drives open and close transfers through the connection limiter and checks
// every result against a cycle-free model of the admission tables. A directed
// part covers limits, denials, duplicate ids and unknown closes. Random
// phases follow under several limit settings, with bursts of idling on both
// channels and one long result hold-off.
// ----------------------------------------------------------------------------
module per_user_connection_limiter_tb;

  localparam int TBL_DEPTH = 1024;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_WAIT = 64;
  localparam logic [pucl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // admission tables as the block should hold them, plus the verdicts still due
  class admission_scoreboard;
    int unsigned max_conn;
    int unsigned user_cap;
    bit          lookup_on;
    logic [pucl_pkg::CONN_W-1:0] conn_key [TBL_DEPTH];
    logic [pucl_pkg::USER_W-1:0] conn_owner [TBL_DEPTH];
    logic [pucl_pkg::USER_W-1:0] user_key [TBL_DEPTH];
    int unsigned                 user_open [TBL_DEPTH];
    int unsigned conn_total;
    int unsigned user_entries;
    pucl_pkg::out_item_t verdicts_due [$];
    int unsigned failures;
    int unsigned reported;

    function new();
      max_conn     = int'(pucl_pkg::RST_LIMIT);
      user_cap     = int'(pucl_pkg::RST_LIMIT);
      lookup_on    = 1'b1;
      conn_total   = 0;
      user_entries = 0;
      failures     = 0;
      reported     = 0;
    endfunction

    function void set_reg(logic [pucl_pkg::CFG_IDX_W-1:0] idx,
                          logic [pucl_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        pucl_pkg::CFG_MAX_CONN:   max_conn = int'(val);
        pucl_pkg::CFG_USER_LIMIT: user_cap = int'(val);
        pucl_pkg::CFG_LOOKUP:     lookup_on = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned global_cap();
      int unsigned m;
      m = (max_conn == 0) ? 1 : max_conn;
      if (m > pucl_pkg::ABS_MAX_CONN) m = pucl_pkg::ABS_MAX_CONN;
      if (m > TBL_DEPTH) m = TBL_DEPTH;
      return m;
    endfunction

    function int unsigned per_user_cap();
      int unsigned g;
      g = global_cap();
      if (!lookup_on || user_cap > g) return g;
      return user_cap;
    endfunction

    function int unsigned find_user(logic [pucl_pkg::USER_W-1:0] key);
      int unsigned k;
      for (k = 0; k < user_entries; k++)
        if (user_key[k] == key) break;
      return k;
    endfunction

    function int unsigned find_conn(logic [pucl_pkg::CONN_W-1:0] key);
      int unsigned k;
      for (k = 0; k < conn_total; k++)
        if (conn_key[k] == key) break;
      return k;
    endfunction

    function void note_request(pucl_pkg::in_item_t it);
      pucl_pkg::out_item_t         r;
      logic [pucl_pkg::USER_W-1:0] who;
      int unsigned                 j, num, i, c;
      r = '0;
      if (it.kind == pucl_pkg::KIND_OPEN) begin
        who = lookup_on ? it.user_id : '0;
        j   = find_user(who);
        num = (j < user_entries) ? user_open[j] : 0;
        if (conn_total >= global_cap()) begin
          r.status     = pucl_pkg::ST_BUSY;
          r.user_count = pucl_pkg::CNT_W'(num);
        end else if (num >= per_user_cap()) begin
          r.status     = pucl_pkg::ST_DENIED;
          r.user_count = pucl_pkg::CNT_W'(num);
        end else if (conn_total < TBL_DEPTH) begin
          if (j < user_entries) begin
            user_open[j] = num + 1;
          end else if (user_entries < TBL_DEPTH) begin
            user_key[user_entries]  = who;
            user_open[user_entries] = 1;
            user_entries++;
          end
          conn_key[conn_total]   = it.conn_id;
          conn_owner[conn_total] = who;
          conn_total++;
          r.status     = pucl_pkg::ST_ACCEPTED;
          r.user_count = pucl_pkg::CNT_W'(num + 1);
        end else begin
          r.status     = pucl_pkg::ST_BUSY;
          r.user_count = pucl_pkg::CNT_W'(num);
        end
      end else begin
        i = find_conn(it.conn_id);
        if (i >= conn_total) begin
          r.status = pucl_pkg::ST_UNKNOWN;
        end else begin
          j = find_user(conn_owner[i]);
          if (j >= user_entries) begin
            r.status = pucl_pkg::ST_INCONSISTENT;
          end else begin
            c = (user_open[j] != 0) ? user_open[j] - 1 : 0;
            user_open[j] = c;
            // last connection of this user: move the tail entry into its slot
            if (c == 0) begin
              user_entries--;
              user_key[j]  = user_key[user_entries];
              user_open[j] = user_open[user_entries];
            end
            r.status     = pucl_pkg::ST_CLOSED;
            r.user_count = pucl_pkg::CNT_W'(c);
          end
          conn_total--;
          conn_key[i]   = conn_key[conn_total];
          conn_owner[i] = conn_owner[conn_total];
        end
      end
      r.open_count = pucl_pkg::CNT_W'(conn_total);
      verdicts_due.push_back(r);
    endfunction

    function void check_result(pucl_pkg::out_item_t got);
      pucl_pkg::out_item_t want;
      if (verdicts_due.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result: status %0d user_count %0d open_count %0d",
                   got.status, got.user_count, got.open_count);
        end
        return;
      end
      want = verdicts_due.pop_front();
      if (got.status !== want.status || got.user_count !== want.user_count ||
          got.open_count !== want.open_count) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: expected status %0d user_count %0d open_count %0d",
                   want.status, want.user_count, want.open_count);
          $display("          actual   status %0d user_count %0d open_count %0d",
                   got.status, got.user_count, got.open_count);
        end
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [pucl_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [pucl_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  pucl_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  pucl_pkg::out_item_t             out_data;

  admission_scoreboard ledger;
  bit quiet;
  bit rx_hold_req;

  per_user_connection_limiter #(
    .TABLE_DEPTH (TBL_DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: random stalls, and one long hold-off when asked for
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left  = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) ledger.check_result(out_data);
  end

  // slowest run: ~320 items plus stalls, taken four times
  initial begin
    #25000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_item(input pucl_pkg::in_item_t it);
    @(negedge clk_i);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk_i); while (!in_ready);
    ledger.note_request(it);
  endtask

  task automatic in_gap(input int unsigned n);
    @(negedge clk_i);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // sender stops until every result has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [pucl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pucl_pkg::CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    ledger.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input int unsigned m, input int unsigned u, input bit lk);
    program_reg(pucl_pkg::CFG_MAX_CONN, pucl_pkg::CFG_DATA_W'(m));
    program_reg(pucl_pkg::CFG_USER_LIMIT, pucl_pkg::CFG_DATA_W'(u));
    program_reg(pucl_pkg::CFG_LOOKUP, pucl_pkg::CFG_DATA_W'(lk));
  endtask

  task automatic open_req(input logic [pucl_pkg::USER_W-1:0] uid,
                          input logic [pucl_pkg::CONN_W-1:0] cid);
    pucl_pkg::in_item_t it;
    it.kind    = pucl_pkg::KIND_OPEN;
    it.user_id = uid;
    it.conn_id = cid;
    push_item(it);
  endtask

  task automatic close_req(input logic [pucl_pkg::CONN_W-1:0] cid);
    pucl_pkg::in_item_t it;
    it.kind    = pucl_pkg::KIND_CLOSE;
    it.user_id = $urandom();
    it.conn_id = cid;
    push_item(it);
  endtask

  function automatic logic [pucl_pkg::USER_W-1:0] pick_user();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h0000_0001;
      3: return 32'h8000_0001;
      4: return 32'h5A5A_A5A5;
      5: return 32'hFFFF_0000;
      default: return $urandom();
    endcase
  endfunction

  // mostly closes of live ids and opens from a small user pool; crowd steers
  // how many connections stay open
  function automatic pucl_pkg::in_item_t next_item(input int unsigned crowd);
    pucl_pkg::in_item_t it;
    int unsigned        roll;
    int unsigned        open_now;
    open_now   = ledger.conn_total;
    it.user_id = pick_user();
    it.conn_id = pucl_pkg::CONN_W'($urandom());
    roll = $urandom_range(0, 99);
    if (open_now == 0) begin
      it.kind = (roll < 8) ? pucl_pkg::KIND_CLOSE : pucl_pkg::KIND_OPEN;
    end else if (open_now > crowd) begin
      it.kind = (roll < 70) ? pucl_pkg::KIND_CLOSE : pucl_pkg::KIND_OPEN;
    end else begin
      it.kind = (roll < 40) ? pucl_pkg::KIND_CLOSE : pucl_pkg::KIND_OPEN;
    end
    roll = $urandom_range(0, 99);
    if (it.kind == pucl_pkg::KIND_CLOSE) begin
      if (open_now != 0 && roll < 88)
        it.conn_id = ledger.conn_key[$urandom_range(0, open_now - 1)];
    end else begin
      if (open_now != 0 && roll < 12)
        it.conn_id = ledger.conn_key[$urandom_range(0, open_now - 1)];
      else if (roll < 18) it.conn_id = '1;
      else if (roll < 24) it.conn_id = '0;
    end
    return it;
  endfunction

  task automatic run_phase(input int unsigned items, input int unsigned crowd,
                           input int hold_at);
    for (int k = 0; k < items; k++) begin
      push_item(next_item(crowd));
      if (k == hold_at) rx_hold_req = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) in_gap($urandom_range(1, 10));
    end
  endtask

  initial begin
    ledger      = new();
    quiet       = 1'b0;
    rx_hold_req = 1'b0;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // global limit two, one connection per user
    configure(2, 1, 1'b1);
    open_req(32'h0000_0000, 22'h000000);
    open_req(32'h0000_0000, 22'h3FFFFF);
    open_req(32'hFFFF_FFFF, 22'h3FFFFF);
    open_req(32'h1234_5678, 22'h000005);
    close_req(22'h000007);
    close_req(22'h000000);
    open_req(32'hFFFF_FFFF, 22'h000000);
    close_req(22'h3FFFFF);

    // per-user limit zero denies everything
    program_reg(pucl_pkg::CFG_USER_LIMIT, 11'd0);
    open_req(32'h0000_0001, 22'h000001);

    // lookup off folds users together; the same id is recorded twice
    program_reg(pucl_pkg::CFG_LOOKUP, 11'd0);
    open_req(32'h0000_AAAA, 22'h000009);
    open_req(32'hAAAA_5555, 22'h000009);
    close_req(22'h000009);
    close_req(22'h000009);

    // zero global limit acts as one; an oversized user limit is clamped
    configure(0, 2047, 1'b1);
    open_req(32'h0000_0003, 22'h000002);
    open_req(32'h0000_0004, 22'h000003);
    configure(2047, 1024, 1'b1);
    open_req(32'h0000_0003, 22'h000004);

    // limit lowered below the open count
    program_reg(pucl_pkg::CFG_MAX_CONN, 11'd1);
    open_req(32'h0000_0004, 22'h000005);
    close_req(22'h000002);
    close_req(22'h000004);
    open_req(32'h0000_0004, 22'h000005);
    close_req(22'h000005);

    configure(40, 40, 1'b1);
    run_phase(45, 12, 20);
    configure(8, 3, 1'b1);
    run_phase(55, 10, -1);
    configure(1024, 1024, 1'b1);
    run_phase(40, 30, -1);
    configure(3, 1, 1'b1);
    run_phase(35, 40, -1);
    program_reg(CFG_SPARE, 11'h7FF);
    configure(5, 0, 1'b1);
    run_phase(20, 8, -1);
    configure(6, 2, 1'b0);
    run_phase(40, 6, -1);
    configure(2047, 11, 1'b1);
    run_phase(25, 15, -1);
    configure(20, 5, 1'b1);
    quiet = 1'b1;
    run_phase(30, 12, -1);

    settle();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
